// ===== sv/ial_pkg.sv =====
`default_nettype none

package ial_pkg;

  // Identifier space and derived widths
  localparam int NUM_IDS = 256;
  localparam int ID_W    = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int CNT_W   = $clog2(NUM_IDS + 1);

  // Fixed field widths of the stream payload
  localparam int IDENT_W  = 8;
  localparam int TAG_W    = 32;
  localparam int STATUS_W = 3;
  localparam int LIVE_W   = 9;
  localparam int OP_W     = 2;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 56;
  localparam int OUT_PAD  = OUT_W - IDENT_W - TAG_W - LIVE_W;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_FREE  = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOT_LIVE = 3'd3,
    ST_DUP_LIVE = 3'd4
  } status_t;

  // Control from the request decode to the free list
  typedef struct packed {
    logic            pop;
    logic            push;
    logic [ID_W-1:0] push_id;
  } fl_ctrl_t;

  function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] p);
    ring_next = (p == ID_W'(NUM_IDS - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ial_ram.sv =====
`default_nettype none

module ial_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ial_free_list.sv =====
`default_nettype none

module ial_free_list
  import ial_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fl_ctrl_t        ctrl,
  output logic      [ID_W-1:0] cand
);

  logic [ID_W-1:0] head, head_next;
  logic [ID_W-1:0] tail, tail_next;
  logic            wrapped, wrapped_next;
  logic            byp_hit;
  logic [ID_W-1:0] byp_data;
  logic            written;
  logic [ID_W-1:0] rdata;

  assign head_next    = ctrl.pop  ? ring_next(head) : head;
  assign tail_next    = ctrl.push ? ring_next(tail) : tail;
  assign wrapped_next = wrapped | (ctrl.push && (tail == ID_W'(NUM_IDS - 1)));

  // Prefetch the slot that will be the head next cycle
  ial_ram #(
    .WIDTH (ID_W),
    .DEPTH (NUM_IDS)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ctrl.push),
    .waddr (tail),
    .wdata (ctrl.push_id),
    .re    (1'b1),
    .raddr (head_next),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      wrapped  <= 1'b0;
      byp_hit  <= 1'b0;
      written  <= 1'b0;
    end else begin
      head     <= head_next;
      tail     <= tail_next;
      wrapped  <= wrapped_next;
      byp_hit  <= ctrl.push && (tail == head_next);
      written  <= wrapped_next || (head_next < tail_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= ctrl.push_id;
  end

  // A slot never pushed still holds its reset identity
  assign cand = byp_hit ? byp_data : (written ? rdata : head);

endmodule

`default_nettype wire

// ===== sv/id_allocator_with_tag_table.sv =====
// Channel   Dir  Bits  Contents (lowest bit first)
// s_axis    in   40    tdata: ident[7:0], tag_in[39:8]; tuser: opcode[1:0]
// m_axis    out  56    tdata: new_ident[7:0], tag_out[39:8], live_count[48:40], zero pad;
//                      tuser: status[2:0]
//
// One transaction is accepted per cycle unless m_axis back-pressure holds the
// pipeline; its result passes through stage one and the output register. The rate
// is set by the single-pass decode against the live bits, with the free-list head prefetched from its RAM.
// Reset is synchronous; there is no clearing pass: slots of the free list
// not yet pushed read as their own index, tracked by the tail and a wrap flag.
// Back-pressure on m_axis holds the pipeline and drops s_axis_tready.
`default_nettype none

module id_allocator_with_tag_table
  import ial_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_W-1:0]   s_axis_tdata,  // ident[7:0], tag_in[39:8]
  input  wire logic [OP_W-1:0]   s_axis_tuser,  // opcode[1:0]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [OUT_W-1:0]  m_axis_tdata,  // new_ident[7:0], tag_out[39:8],
                                                // live_count[48:40], zero pad
  output logic      [STATUS_W-1:0] m_axis_tuser // status[2:0]
);

  // Request fields
  op_t              op;
  logic [IDENT_W-1:0] ident;
  logic [TAG_W-1:0] tag_in;
  logic [ID_W-1:0]  idx;
  logic             in_range;

  assign op     = op_t'(s_axis_tuser);
  assign ident  = s_axis_tdata[IDENT_W-1:0];
  assign tag_in = s_axis_tdata[IDENT_W +: TAG_W];
  assign idx    = ID_W'(ident);
  assign in_range = (32'(ident) < NUM_IDS);

  // State
  logic [NUM_IDS-1:0] live_bits;
  logic [CNT_W-1:0]   live_total, live_total_next;
  logic [ID_W-1:0]    cand;

  // Pipeline registers
  logic               s1_valid, s1_adv;
  status_t            s1_status;
  logic [IDENT_W-1:0] s1_new_ident;
  logic [LIVE_W-1:0]  s1_live;
  logic               s1_rd;
  logic               out_valid;
  status_t            out_status;
  logic [IDENT_W-1:0] out_new_ident;
  logic [TAG_W-1:0]   out_tag;
  logic [LIVE_W-1:0]  out_live;

  logic               accept;
  status_t            status;
  logic               pop_ok, free_ok, wr_ok, rd_ok;
  logic [TAG_W-1:0]   tag_rdata;
  fl_ctrl_t           fl_ctrl;

  // Advance stage one when the output register is free or being drained
  assign s1_adv        = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Decode one request against the current state
  always_comb begin
    status  = ST_OK;
    pop_ok  = 1'b0;
    free_ok = 1'b0;
    wr_ok   = 1'b0;
    rd_ok   = 1'b0;
    priority if (op == OP_ALLOC) begin
      priority if (live_total >= CNT_W'(NUM_IDS)) begin
        status = ST_NO_FREE;
      end else if (live_bits[cand]) begin
        status = ST_DUP_LIVE;
      end else begin
        pop_ok = 1'b1;
      end
    end else if (!in_range) begin
      status = ST_RANGE;
    end else if (!live_bits[idx]) begin
      status = ST_NOT_LIVE;
    end else begin
      unique case (op)
        OP_FREE:  free_ok = 1'b1;
        OP_WRITE: wr_ok   = 1'b1;
        OP_READ:  rd_ok   = 1'b1;
        default:  status  = ST_OK;
      endcase
    end
  end

  always_comb begin
    live_total_next = live_total;
    if (accept && pop_ok) begin
      live_total_next = live_total + 1'b1;
    end else if (accept && free_ok) begin
      live_total_next = live_total - 1'b1;
    end
  end

  assign fl_ctrl.pop     = accept && pop_ok;
  assign fl_ctrl.push    = accept && free_ok;
  assign fl_ctrl.push_id = idx;

  ial_free_list u_free_list (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fl_ctrl),
    .cand (cand)
  );

  // Tag table: clear on allocate and free, load on write, read on every accept
  ial_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_IDS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (accept && (pop_ok || free_ok || wr_ok)),
    .waddr (pop_ok ? cand : idx),
    .wdata (wr_ok ? tag_in : '0),
    .re    (accept),
    .raddr (idx),
    .rdata (tag_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      live_bits  <= '0;
      live_total <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && pop_ok) begin
        live_bits[cand] <= 1'b1;
      end
      if (accept && free_ok) begin
        live_bits[idx] <= 1'b0;
      end
      live_total <= live_total_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold stage one while stalled, load the result on advance
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status    <= status;
      s1_new_ident <= pop_ok ? IDENT_W'(cand) : '0;
      s1_live      <= LIVE_W'(live_total_next);
      s1_rd        <= rd_ok;
    end
    if (s1_adv) begin
      out_status    <= s1_status;
      out_new_ident <= s1_new_ident;
      out_tag       <= s1_rd ? tag_rdata : '0;
      out_live      <= s1_live;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_live, out_tag, out_new_ident};
  assign m_axis_tuser  = out_status;

  // The live count tracks the live bits exactly
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(live_bits) == 32'(live_total))
    else $error("live count differs from live bits");

  // The free list never hands out an identifier that is already live
  a_no_dup_live: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status != ST_DUP_LIVE))
    else $error("allocate popped a live identifier");

  // Error results carry no identifier and no tag
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != ST_OK)) |-> ((out_new_ident == '0) && (out_tag == '0)))
    else $error("error result carries data");

  // A stalled transaction in stage one is never lost
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stage one dropped a transaction");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import ial_pkg::*;
();

  // One response as seen on m_axis, split into its fields
  typedef struct packed {
    status_t             status;
    logic [IDENT_W-1:0]  new_id;
    logic [TAG_W-1:0]    tag;
    logic [LIVE_W-1:0]   live;
  } resp_t;

  // One row of the directed table; typed rows carry a hand-written response
  typedef struct packed {
    op_t                 op;
    logic [IDENT_W-1:0]  id;
    logic [TAG_W-1:0]    tag;
    logic                typed;
    resp_t               want;
  } dir_row_t;

  // Traffic shapes for the random part
  typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED, SEG_NOISE} seg_mode_t;
  // Back-pressure shapes on m_axis
  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

  localparam int DIR_N       = 25;
  localparam int RAND_N      = 1925;
  localparam int HOLD_AT     = 700;   // transactions accepted before the long hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;     // ident[7:0], tag_in[39:8]
  logic [OP_W-1:0]     s_axis_tuser = OP_ALLOC; // opcode[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;          // new_ident[7:0], tag_out[39:8],
                                              // live_count[48:40], zero pad
  logic [STATUS_W-1:0] m_axis_tuser;          // status[2:0]

  id_allocator_with_tag_table u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Shadow of the allocator: free list in pop order, live flags, tag words, count
  logic [ID_W-1:0]  free_ids [$];
  bit               id_live [NUM_IDS];
  logic [TAG_W-1:0] tag_mem [NUM_IDS];
  int               live_n;

  resp_t pending_resp [$];   // responses still owed by the block, oldest first
  int    accepted_n = 0;
  int    fail_n     = 0;

  // Work out the response to one request and advance the shadow state.
  function automatic resp_t predict_response(input op_t op, input logic [IDENT_W-1:0] id,
                                             input logic [TAG_W-1:0] tag);
    resp_t           r;
    logic [ID_W-1:0] cand;
    r.status = ST_OK;
    r.new_id = '0;
    r.tag    = '0;
    if (op == OP_ALLOC) begin
      if (live_n >= NUM_IDS) begin
        r.status = ST_NO_FREE;
      end else begin
        cand = free_ids[0];
        // A popped id that is already live cannot happen while the list is consistent
        if (id_live[cand]) begin
          r.status = ST_DUP_LIVE;
        end else begin
          void'(free_ids.pop_front());
          id_live[cand] = 1'b1;
          tag_mem[cand] = '0;
          live_n++;
          r.new_id = IDENT_W'(cand);
        end
      end
    end else if (int'(id) >= NUM_IDS) begin
      r.status = ST_RANGE;
    end else if (!id_live[id]) begin
      r.status = ST_NOT_LIVE;
    end else if (op == OP_FREE) begin
      tag_mem[id] = '0;
      id_live[id] = 1'b0;
      free_ids.push_back(ID_W'(id));
      if (live_n > 0) live_n--;
    end else if (op == OP_WRITE) begin
      tag_mem[id] = tag;
    end else begin
      r.tag = tag_mem[id];
    end
    r.live = LIVE_W'(live_n);
    return r;
  endfunction

  // Offer one request from the falling edge and hold it until the block takes it.
  // Valid stays high from here into the next request of a burst.
  task automatic issue(input op_t op, input logic [IDENT_W-1:0] id,
                       input logic [TAG_W-1:0] tag, input logic typed, input resp_t want);
    resp_t r;
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tag, id};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    r = predict_response(op, id, tag);
    pending_resp.push_back(typed ? want : r);
    accepted_n++;
  endtask

  // Drop valid between bursts; n sets how long it stays low
  task automatic pause_sender(input int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Mostly pick a live identifier so that free, write and read get past the checks
  function automatic logic [IDENT_W-1:0] pick_ident();
    int start;
    if (live_n != 0 && $urandom_range(0, 9) < 8) begin
      start = $urandom_range(0, NUM_IDS - 1);
      for (int k = 0; k < NUM_IDS; k++)
        if (id_live[(start + k) % NUM_IDS]) return IDENT_W'((start + k) % NUM_IDS);
    end
    return IDENT_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [TAG_W-1:0] make_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TAG_W'(1) << $urandom_range(0, TAG_W - 1);
      default: return TAG_W'($urandom);
    endcase
  endfunction

  // Directed rows. An 8-bit ident cannot leave the 256-entry id space, so the
  // out-of-range status has no stimulus; running out of ids is reached in the
  // random fill segments.
  dir_row_t dir_tab [DIR_N] = '{
    '{OP_ALLOC, 8'h00, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd1}},
    '{OP_ALLOC, 8'h00, 32'h0000_0000, 1'b1, '{ST_OK,       8'd1, 32'h0000_0000, 9'd2}},
    '{OP_ALLOC, 8'h00, 32'h0000_0000, 1'b1, '{ST_OK,       8'd2, 32'h0000_0000, 9'd3}},
    '{OP_WRITE, 8'h00, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd3}},
    '{OP_READ,  8'h00, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'hFFFF_FFFF, 9'd3}},
    '{OP_WRITE, 8'h01, 32'hA5A5_5A5A, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd3}},
    '{OP_READ,  8'h01, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'hA5A5_5A5A, 9'd3}},
    '{OP_READ,  8'h02, 32'hFFFF_FFFF, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd3}},
    '{OP_READ,  8'hFF, 32'h0000_0000, 1'b1, '{ST_NOT_LIVE, 8'd0, 32'h0000_0000, 9'd3}},
    '{OP_FREE,  8'hFF, 32'h0000_0000, 1'b1, '{ST_NOT_LIVE, 8'd0, 32'h0000_0000, 9'd3}},
    '{OP_WRITE, 8'h80, 32'hFFFF_FFFF, 1'b1, '{ST_NOT_LIVE, 8'd0, 32'h0000_0000, 9'd3}},
    '{OP_FREE,  8'h01, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd2}},
    '{OP_READ,  8'h01, 32'h0000_0000, 1'b1, '{ST_NOT_LIVE, 8'd0, 32'h0000_0000, 9'd2}},
    '{OP_FREE,  8'h01, 32'h0000_0000, 1'b1, '{ST_NOT_LIVE, 8'd0, 32'h0000_0000, 9'd2}},
    '{OP_WRITE, 8'h00, 32'h0000_0001, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd2}},
    '{OP_READ,  8'h00, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0001, 9'd2}},
    '{OP_WRITE, 8'h02, 32'h8000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd2}},
    '{OP_READ,  8'h02, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h8000_0000, 9'd2}},
    '{OP_FREE,  8'h00, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd1}},
    '{OP_ALLOC, 8'hFF, 32'hFFFF_FFFF, 1'b0, '{ST_OK,       8'd0, 32'h0000_0000, 9'd0}},
    '{OP_FREE,  8'h02, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd1}},
    '{OP_FREE,  8'h03, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd0}},
    '{OP_READ,  8'h00, 32'h0000_0000, 1'b1, '{ST_NOT_LIVE, 8'd0, 32'h0000_0000, 9'd0}},
    '{OP_ALLOC, 8'h00, 32'h0000_0000, 1'b0, '{ST_OK,       8'd0, 32'h0000_0000, 9'd0}},
    '{OP_FREE,  8'h04, 32'h0000_0000, 1'b1, '{ST_OK,       8'd0, 32'h0000_0000, 9'd0}}
  };

  // Random traffic in segments: fill the id space until it runs out, drain it,
  // mix all operations, or throw unshaped noise at it. The sender bursts with
  // random gaps, and some bursts are long enough to leave no idle at all.
  task automatic run_random(input int n_items);
    seg_mode_t mode;
    int        seg_left;
    int        burst_left;
    int        done;
    int        d;
    bit        topped_up;
    op_t       op;
    mode       = SEG_FILL;
    seg_left   = 600;
    burst_left = 0;
    done       = 0;
    topped_up  = 1'b0;
    while (done < n_items) begin
      if (seg_left == 0) begin
        d         = $urandom_range(0, 9);
        mode      = (d < 3) ? SEG_FILL : (d < 6) ? SEG_DRAIN : (d < 9) ? SEG_MIXED : SEG_NOISE;
        seg_left  = (mode == SEG_FILL) ? 600 : $urandom_range(20, 160);
        topped_up = 1'b0;
      end
      // once full, keep allocating a few more times to hit the empty free list
      if (mode == SEG_FILL && live_n == NUM_IDS && !topped_up) begin
        topped_up = 1'b1;
        seg_left  = $urandom_range(3, 10);
      end
      seg_left--;

      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 48);
      end
      burst_left--;

      d = $urandom_range(0, 99);
      case (mode)
        SEG_FILL:  op = (d < 75) ? OP_ALLOC : (d < 85) ? OP_WRITE : (d < 93) ? OP_READ : OP_FREE;
        SEG_DRAIN: op = (d < 65) ? OP_FREE : (d < 80) ? OP_READ : (d < 90) ? OP_WRITE : OP_ALLOC;
        SEG_MIXED: op = (d < 30) ? OP_ALLOC : (d < 55) ? OP_FREE : (d < 78) ? OP_WRITE : OP_READ;
        default:   op = op_t'($urandom_range(0, 3));
      endcase
      issue(op, (mode == SEG_NOISE) ? IDENT_W'($urandom_range(0, 255)) : pick_ident(),
            make_tag(), 1'b0, '0);
      done++;
    end
  endtask

  // Receiver: shift between back-pressure shapes at random intervals, and once,
  // part-way through, hold off long enough for the block to fill and stall s_axis.
  rx_mode_t   rx_mode     = RX_OPEN;
  int         rx_left     = 0;
  logic [7:0] rx_pat      = 8'h5A;
  int         hold_left   = 0;
  bit         hold_done   = 1'b0;

  always @(negedge clk) begin
    if (!hold_done && accepted_n >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
        rx_pat  = 8'($urandom);
        if (rx_pat == 8'h00) rx_pat = 8'h5A;
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:    m_axis_tready <= 1'b1;
        RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
        RX_PATTERN: begin
          m_axis_tready <= rx_pat[0];
          rx_pat = {rx_pat[0], rx_pat[7:1]};
        end
        default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare every response taken off m_axis with the oldest one owed
  always @(posedge clk) begin
    resp_t want;
    resp_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tuser);
      got.new_id = m_axis_tdata[7:0];
      got.tag    = m_axis_tdata[39:8];
      got.live   = m_axis_tdata[48:40];
      if (pending_resp.size() == 0) begin
        fail_n++;
        if (fail_n <= MAX_REPORTS)
          $display("%0t: response with none owed: status=%0d id=%0d tag=%h live=%0d",
                   $realtime, got.status, got.new_id, got.tag, got.live);
      end else begin
        want = pending_resp.pop_front();
        if (got !== want) begin
          fail_n++;
          if (fail_n <= MAX_REPORTS)
            $display("%0t: mismatch: want status=%0d id=%0d tag=%h live=%0d,",
                     $realtime, want.status, want.new_id, want.tag, want.live,
                     " got status=%0d id=%0d tag=%h live=%0d",
                     got.status, got.new_id, got.tag, got.live);
        end
      end
    end
  end

  initial begin
    // Shadow state after reset: every id free, in ascending order
    for (int i = 0; i < NUM_IDS; i++) begin
      free_ids.push_back(ID_W'(i));
      id_live[i] = 1'b0;
      tag_mem[i] = '0;
    end
    live_n = 0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      issue(dir_tab[i].op, dir_tab[i].id, dir_tab[i].tag, dir_tab[i].typed, dir_tab[i].want);
    run_random(RAND_N);

    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Let every owed response drain, then watch a little longer for strays
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_n == 0 && pending_resp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(4_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== id_allocator_with_tag_table.f =====
sv/ial_pkg.sv
sv/ial_ram.sv
sv/ial_free_list.sv
sv/id_allocator_with_tag_table.sv
tb/sv/tb_top.sv
